@@ sv/mpq_pkg.sv @@
`default_nettype none

package mpq_pkg;

   // Width of one stored element
   localparam int DATA_W = 32;

   // Request opcodes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Broadcast from the control side to every cell of the chain
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/mpq_cell.sv @@
`default_nettype none

module mpq_cell (
   input  wire                                   clock,
   input  wire mpq_pkg::cell_ctrl_type           ctrl,
   input  wire                                   occ,
   input  wire                                   prev_ge,
   input  wire signed [mpq_pkg::DATA_W-1:0]      prev_data,
   input  wire signed [mpq_pkg::DATA_W-1:0]      next_data,
   output logic                                  ge,
   output logic signed [mpq_pkg::DATA_W-1:0]     data
);
   import mpq_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // Occupied and at least as large as the incoming value: stays ahead of it
   assign ge   = occ && (data_ff >= ctrl.value);
   assign data = data_ff;

   // Insert: keep, take the new value, or take the left neighbor's entry.
   // Delete: take the right neighbor's entry.
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (ge) begin
            data_in = data_ff;
         end else if (prev_ge) begin
            data_in = ctrl.value;
         end else begin
            data_in = prev_data;
         end
      end else if (ctrl.del) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ sv/max_priority_queue.sv @@
// Channel  | Direction | Signals                                      | Accepted when
// req      | in        | req_valid, req_ready, req_command, req_value | req_valid && req_ready
// rsp      | out       | rsp_valid, rsp_ready, rsp_result_value,      | rsp_valid && rsp_ready
//          |           | rsp_status                                   |
//
// A request is first registered; once the previous response has been taken,
// the cell chain inserts it (sorted, largest at cell 0) or shifts out cell 0.
// Every cell moves in the same cycle, so a request's timing does not depend on CAPACITY.
// Synchronous active-high reset empties the queue; cell contents are not reset.
// A stalled response holds the pending request, and req_ready stays low
// until that request has been applied.
`default_nettype none

module max_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_command,
   input  wire signed [mpq_pkg::DATA_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [mpq_pkg::DATA_W-1:0]  rsp_result_value,
   output logic [1:0]                         rsp_status
);
   import mpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                      busy_ff, busy_in;
   logic                      cmd_ff;
   logic signed [DATA_W-1:0]  val_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   logic                      req_take;
   logic                      apply;
   logic                      is_full;
   logic                      is_empty;
   cell_ctrl_type             ctrl;

   logic signed [DATA_W-1:0]  cell_data [CAPACITY];
   logic                      cell_ge   [CAPACITY];

   assign req_ready        = !busy_ff;
   assign req_take         = req_valid && req_ready;
   assign apply            = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign is_full          = (count_ff == CNT_W'(CAPACITY));
   assign is_empty         = (count_ff == '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // Commands broadcast to the chain
   always_comb begin
      ctrl.value = val_ff;
      ctrl.ins   = apply && (cmd_ff == CMD_ENQUEUE) && !is_full;
      ctrl.del   = apply && (cmd_ff == CMD_DEQUEUE) && !is_empty;
   end

   // Cell chain, largest at cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      occ;
      logic                      prev_ge;
      logic signed [DATA_W-1:0]  prev_data;
      logic signed [DATA_W-1:0]  next_data;

      assign occ = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_ge   = 1'b1;
         assign prev_data = cell_data[i];
      end else begin : g_body
         assign prev_ge   = cell_ge[i-1];
         assign prev_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      mpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occ       (occ),
         .prev_ge   (prev_ge),
         .prev_data (prev_data),
         .next_data (next_data),
         .ge        (cell_ge[i]),
         .data      (cell_data[i])
      );
   end

   // Control and response next state
   always_comb begin
      busy_in       = busy_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (apply) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = STATUS_OK;
         if (cmd_ff == CMD_ENQUEUE) begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_value_in = cell_data[0];
               count_in     = count_ff - CNT_W'(1);
            end
         end
      end

      if (req_take) begin
         busy_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire
